// ===== hdl/prq_pkg.sv =====
package prq_pkg;

  localparam int FUNC_W = 2;
  localparam int TASK_W = 4;
  localparam int PRIO_W = 6;
  localparam int MASK_W = 32;
  localparam int LEN_W  = 5;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_REMOVE = 2'd1,
    FUNC_ROTATE = 2'd2,
    FUNC_QUERY  = 2'd3
  } func_t;

endpackage

// ===== hdl/priority_ready_queue.sv =====
// priority ready queue: one fifo per priority level over task slots, plus
// a bitmap of the nonempty levels. level 0 is the most urgent.
// input channel: in_func, in_task_id, in_prio_level with in_valid/in_stall.
// an input word is taken when in_valid is high and in_stall is low.
// result channel: out_ok, out_top_valid, out_top_task, out_ready_mask and
// out_level_length with out_valid/out_stall, one result word per input.
// the input word is registered; the list update and the result are
// computed from the input register and land in the output register.
// throughput is one word per cycle unless out_stall holds the output;
// the whole link state sits in flip-flops, so each operation is a single
// read-modify-write of the slot and level tables with no list walking.
// when the receiver stalls, the result holds in the output register and
// one more word is held in the input register; then in_stall rises.
// synchronous reset empties every level and clears both pipeline stages;
// link tables are only read through entries written since reset.
module priority_ready_queue #(
  parameter int LEVELS     = 32,
  parameter int TASK_SLOTS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [prq_pkg::FUNC_W-1:0]  in_func,
  input  logic [prq_pkg::TASK_W-1:0]  in_task_id,
  input  logic [prq_pkg::PRIO_W-1:0]  in_prio_level,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_ok,
  output logic                        out_top_valid,
  output logic [prq_pkg::TASK_W-1:0]  out_top_task,
  output logic [prq_pkg::MASK_W-1:0]  out_ready_mask,
  output logic [prq_pkg::LEN_W-1:0]   out_level_length
);

  localparam int SW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam int LW = $clog2(TASK_SLOTS + 1);
  localparam int PW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int CW = $clog2(TASK_SLOTS + 1);
  localparam logic [LW-1:0] NO_LINK = LW'(TASK_SLOTS);

  // input stage
  logic                        s1_valid_r;
  prq_pkg::func_t              s1_func_r;
  logic [prq_pkg::TASK_W-1:0]  s1_task_r;
  logic [prq_pkg::PRIO_W-1:0]  s1_prio_r;

  // queue state
  logic            queued_r [TASK_SLOTS];
  logic [PW-1:0]   level_r  [TASK_SLOTS];
  logic [LW-1:0]   next_r   [TASK_SLOTS];
  logic [LW-1:0]   prev_r   [TASK_SLOTS];
  logic [SW-1:0]   head_r   [LEVELS];
  logic [SW-1:0]   tail_r   [LEVELS];
  logic [CW-1:0]   count_r  [LEVELS];
  logic [LEVELS-1:0] mask_r;

  // output register
  logic                        out_valid_r;
  logic                        out_ok_r;
  logic                        out_top_valid_r;
  logic [prq_pkg::TASK_W-1:0]  out_top_task_r;
  logic [prq_pkg::MASK_W-1:0]  out_ready_mask_r;
  logic [prq_pkg::LEN_W-1:0]   out_level_length_r;

  logic              adv;
  logic              t_ok, p_ok;
  logic [SW-1:0]     ti;
  logic [PW-1:0]     pi;
  logic [CW-1:0]     cnt, cnt_nxt;
  logic [SW-1:0]     hd, tl, hp_nxt;
  logic [LW-1:0]     pv, nx, nh;
  logic              ok, do_ins, do_rem, do_rot;
  logic [LEVELS-1:0] mask_nxt;
  logic [PW-1:0]     top_lv;
  logic              top_any;
  logic [SW-1:0]     top_head;

  assign adv      = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !adv;

  assign t_ok = (7'(s1_task_r) < 7'(TASK_SLOTS));
  assign p_ok = (7'(s1_prio_r) < 7'(LEVELS));
  assign ti   = SW'(s1_task_r);
  assign pi   = PW'(s1_prio_r);

  assign cnt = count_r[pi];
  assign hd  = head_r[pi];
  assign tl  = tail_r[pi];
  assign pv  = prev_r[ti];
  assign nx  = next_r[ti];
  assign nh  = next_r[hd];

  always_comb begin
    ok     = 1'b1;
    do_ins = 1'b0;
    do_rem = 1'b0;
    do_rot = 1'b0;
    case (s1_func_r)
      prq_pkg::FUNC_INSERT: begin
        ok     = t_ok && p_ok && !queued_r[ti];
        do_ins = ok;
      end
      prq_pkg::FUNC_REMOVE: begin
        ok     = t_ok && p_ok && queued_r[ti] && (level_r[ti] == pi);
        do_rem = ok;
      end
      prq_pkg::FUNC_ROTATE: begin
        ok     = p_ok;
        do_rot = p_ok && (cnt > CW'(1));
      end
      prq_pkg::FUNC_QUERY: begin
        ok = 1'b1;
      end
      default: begin
        ok = 1'b1;
      end
    endcase
  end

  // new count, head and bitmap of the addressed level
  always_comb begin
    cnt_nxt  = cnt;
    hp_nxt   = hd;
    mask_nxt = mask_r;
    if (do_ins) begin
      cnt_nxt = CW'(cnt + 1'b1);
      if (cnt == '0) begin
        hp_nxt = ti;
      end
      mask_nxt[pi] = 1'b1;
    end
    if (do_rem) begin
      if (pv == NO_LINK) begin
        hp_nxt = SW'(nx);
      end
      cnt_nxt = (cnt == '0) ? '0 : CW'(cnt - 1'b1);
      if (cnt_nxt == '0) begin
        mask_nxt[pi] = 1'b0;
      end
    end
    if (do_rot) begin
      hp_nxt = SW'(nh);
    end
  end

  // most urgent nonempty level
  always_comb begin
    top_lv  = '0;
    top_any = 1'b0;
    for (int i = LEVELS - 1; i >= 0; i--) begin
      if (mask_nxt[i]) begin
        top_lv  = PW'(i);
        top_any = 1'b1;
      end
    end
    top_head = (p_ok && (top_lv == pi)) ? hp_nxt : head_r[top_lv];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_func_r <= prq_pkg::func_t'(in_func);
      s1_task_r <= in_task_id;
      s1_prio_r <= in_prio_level;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= '0;
      for (int i = 0; i < TASK_SLOTS; i++) begin
        queued_r[i] <= 1'b0;
      end
      for (int i = 0; i < LEVELS; i++) begin
        count_r[i] <= '0;
      end
    end else if (adv) begin
      mask_r <= mask_nxt;
      if (do_ins || do_rem) begin
        count_r[pi] <= cnt_nxt;
      end
      if (do_ins) begin
        queued_r[ti] <= 1'b1;
      end
      if (do_rem) begin
        queued_r[ti] <= 1'b0;
      end
    end
  end

  // link tables
  always_ff @(posedge clk) begin
    if (adv) begin
      if (do_ins) begin
        next_r[ti]  <= NO_LINK;
        level_r[ti] <= pi;
        tail_r[pi]  <= ti;
        if (cnt == '0) begin
          prev_r[ti] <= NO_LINK;
          head_r[pi] <= ti;
        end else begin
          prev_r[ti] <= LW'(tl);
          next_r[tl] <= LW'(ti);
        end
      end
      if (do_rem) begin
        if (pv != NO_LINK) begin
          next_r[SW'(pv)] <= nx;
        end else begin
          head_r[pi] <= SW'(nx);
        end
        if (nx != NO_LINK) begin
          prev_r[SW'(nx)] <= pv;
        end else begin
          tail_r[pi] <= SW'(pv);
        end
      end
      if (do_rot) begin
        head_r[pi]      <= SW'(nh);
        prev_r[SW'(nh)] <= NO_LINK;
        next_r[hd]      <= NO_LINK;
        prev_r[hd]      <= LW'(tl);
        next_r[tl]      <= LW'(hd);
        tail_r[pi]      <= hd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_ok_r           <= ok;
      out_top_valid_r    <= top_any;
      out_top_task_r     <= top_any ? prq_pkg::TASK_W'(top_head) : '0;
      out_ready_mask_r   <= prq_pkg::MASK_W'(mask_nxt);
      out_level_length_r <= p_ok ? prq_pkg::LEN_W'(cnt_nxt) : '0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_ok           = out_ok_r;
  assign out_top_valid    = out_top_valid_r;
  assign out_top_task     = out_top_task_r;
  assign out_ready_mask   = out_ready_mask_r;
  assign out_level_length = out_level_length_r;

endmodule

// ===== test/priority_ready_queue_tb.sv =====
module priority_ready_queue_tb;

  localparam int LEVELS      = 32;
  localparam int TASK_SLOTS  = 16;
  localparam logic [4:0] END_LINK = 5'(TASK_SLOTS);
  localparam int HOLD_CYCLES = 200;
  localparam int LIMIT       = 200000;

  typedef struct packed {
    logic                       ok;
    logic                       top_valid;
    logic [prq_pkg::TASK_W-1:0] top_task;
    logic [prq_pkg::MASK_W-1:0] ready_mask;
    logic [prq_pkg::LEN_W-1:0]  level_length;
  } ready_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  prq_pkg::func_t in_func = prq_pkg::FUNC_QUERY;
  logic [prq_pkg::TASK_W-1:0] in_task_id = '0;
  logic [prq_pkg::PRIO_W-1:0] in_prio_level = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_ok;
  logic out_top_valid;
  logic [prq_pkg::TASK_W-1:0] out_top_task;
  logic [prq_pkg::MASK_W-1:0] out_ready_mask;
  logic [prq_pkg::LEN_W-1:0] out_level_length;

  // shadow copy of the scheduler lists
  logic       task_queued [TASK_SLOTS];
  logic [4:0] task_level  [TASK_SLOTS];
  logic [4:0] link_next   [TASK_SLOTS];
  logic [4:0] link_prev   [TASK_SLOTS];
  logic [3:0] lvl_head    [LEVELS];
  logic [3:0] lvl_tail    [LEVELS];
  logic [4:0] lvl_count   [LEVELS];
  logic [31:0] busy_levels;

  ready_word_t pending_results[$];
  int error_count = 0;
  int words_sent = 0;
  int words_checked = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_requests = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int cycle_count = 0;

  priority_ready_queue #(
    .LEVELS     (LEVELS),
    .TASK_SLOTS (TASK_SLOTS)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_func          (in_func),
    .in_task_id       (in_task_id),
    .in_prio_level    (in_prio_level),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_ok           (out_ok),
    .out_top_valid    (out_top_valid),
    .out_top_task     (out_top_task),
    .out_ready_mask   (out_ready_mask),
    .out_level_length (out_level_length)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

  // receiver stall, with a long hold-off on request
  always @(posedge clk) begin
    if (hold_seen != hold_requests) begin
      hold_seen <= hold_requests;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  function automatic ready_word_t apply_ready_op(prq_pkg::func_t f, logic [3:0] t,
                                                 logic [5:0] p);
    ready_word_t r;
    logic ok;
    logic [4:0] lv;
    logic [4:0] pv;
    logic [4:0] nx;
    logic [3:0] h;
    logic [4:0] nh;
    lv = p[4:0];
    ok = 1'b1;
    case (f)
      prq_pkg::FUNC_INSERT: begin
        if (p >= LEVELS || task_queued[t]) begin
          ok = 1'b0;
        end else begin
          link_next[t] = END_LINK;
          if (lvl_count[lv] == 0) begin
            link_prev[t] = END_LINK;
            lvl_head[lv] = t;
          end else begin
            link_prev[t] = {1'b0, lvl_tail[lv]};
            link_next[lvl_tail[lv]] = {1'b0, t};
          end
          lvl_tail[lv] = t;
          lvl_count[lv] = lvl_count[lv] + 5'd1;
          task_queued[t] = 1'b1;
          task_level[t] = lv;
          busy_levels[lv] = 1'b1;
        end
      end
      prq_pkg::FUNC_REMOVE: begin
        if (p >= LEVELS || !task_queued[t] || task_level[t] != lv) begin
          ok = 1'b0;
        end else begin
          pv = link_prev[t];
          nx = link_next[t];
          if (pv < END_LINK) link_next[pv[3:0]] = nx;
          else lvl_head[lv] = nx[3:0];
          if (nx < END_LINK) link_prev[nx[3:0]] = pv;
          else lvl_tail[lv] = pv[3:0];
          if (lvl_count[lv] > 0) lvl_count[lv] = lvl_count[lv] - 5'd1;
          if (lvl_count[lv] == 0) busy_levels[lv] = 1'b0;
          task_queued[t] = 1'b0;
        end
      end
      prq_pkg::FUNC_ROTATE: begin
        if (p >= LEVELS) begin
          ok = 1'b0;
        end else if (lvl_count[lv] > 1) begin
          h = lvl_head[lv];
          nh = link_next[h];
          lvl_head[lv] = nh[3:0];
          link_prev[nh[3:0]] = END_LINK;
          link_next[h] = END_LINK;
          link_prev[h] = {1'b0, lvl_tail[lv]};
          link_next[lvl_tail[lv]] = {1'b0, h};
          lvl_tail[lv] = h;
        end
      end
      default: ok = 1'b1;
    endcase
    r = '0;
    r.ok = ok;
    // lowest nonempty level wins, so scan downward
    for (int i = LEVELS - 1; i >= 0; i--) begin
      if (busy_levels[i]) begin
        r.top_valid = 1'b1;
        r.top_task = lvl_head[i];
      end
    end
    r.ready_mask = busy_levels;
    r.level_length = (p < LEVELS) ? lvl_count[lv] : '0;
    return r;
  endfunction

  function automatic int pick_queued_task();
    int start;
    start = $urandom_range(TASK_SLOTS - 1);
    for (int i = 0; i < TASK_SLOTS; i++) begin
      if (task_queued[(start + i) % TASK_SLOTS]) return (start + i) % TASK_SLOTS;
    end
    return -1;
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result word with nothing expected");
        error_count++;
      end else begin
        ready_word_t exp_w;
        exp_w = pending_results.pop_front();
        words_checked++;
        if (out_ok !== exp_w.ok) begin
          $error("ok expected %0h actual %0h", exp_w.ok, out_ok);
          error_count++;
        end
        if (out_top_valid !== exp_w.top_valid) begin
          $error("top_valid expected %0h actual %0h", exp_w.top_valid, out_top_valid);
          error_count++;
        end
        if (out_top_task !== exp_w.top_task) begin
          $error("top_task expected %0h actual %0h", exp_w.top_task, out_top_task);
          error_count++;
        end
        if (out_ready_mask !== exp_w.ready_mask) begin
          $error("ready_mask expected %0h actual %0h", exp_w.ready_mask, out_ready_mask);
          error_count++;
        end
        if (out_level_length !== exp_w.level_length) begin
          $error("level_length expected %0h actual %0h", exp_w.level_length,
                 out_level_length);
          error_count++;
        end
      end
    end
  end

  task automatic send_word(prq_pkg::func_t f, logic [3:0] t, logic [5:0] p);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func <= f;
    in_task_id <= t;
    in_prio_level <= p;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(apply_ready_op(f, t, p));
    words_sent++;
  endtask

  task automatic wait_results_empty();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    send_idle_pct = 0;
    recv_idle_pct = 20;
    send_word(prq_pkg::FUNC_QUERY,  4'd0,  6'd0);
    send_word(prq_pkg::FUNC_ROTATE, 4'd0,  6'd5);
    send_word(prq_pkg::FUNC_INSERT, 4'd0,  6'd31);
    send_word(prq_pkg::FUNC_INSERT, 4'd15, 6'd0);
    send_word(prq_pkg::FUNC_INSERT, 4'd15, 6'd3);
    send_word(prq_pkg::FUNC_INSERT, 4'd1,  6'd32);
    send_word(prq_pkg::FUNC_INSERT, 4'd2,  6'd63);
    send_word(prq_pkg::FUNC_ROTATE, 4'd0,  6'd0);
    send_word(prq_pkg::FUNC_ROTATE, 4'd0,  6'd63);
    send_word(prq_pkg::FUNC_INSERT, 4'd3,  6'd0);
    send_word(prq_pkg::FUNC_INSERT, 4'd4,  6'd0);
    send_word(prq_pkg::FUNC_ROTATE, 4'd9,  6'd0);
    send_word(prq_pkg::FUNC_REMOVE, 4'd4,  6'd0);
    send_word(prq_pkg::FUNC_REMOVE, 4'd5,  6'd0);
    send_word(prq_pkg::FUNC_REMOVE, 4'd0,  6'd30);
    send_word(prq_pkg::FUNC_REMOVE, 4'd0,  6'd63);
    send_word(prq_pkg::FUNC_REMOVE, 4'd3,  6'd0);
    send_word(prq_pkg::FUNC_REMOVE, 4'd15, 6'd0);
    send_word(prq_pkg::FUNC_QUERY,  4'd15, 6'd40);
    send_word(prq_pkg::FUNC_REMOVE, 4'd0,  6'd31);
    send_word(prq_pkg::FUNC_QUERY,  4'd7,  6'd31);
  endtask

  task automatic test_random(int count, int send_pct, int recv_pct);
    prq_pkg::func_t f;
    logic [3:0] t;
    logic [5:0] p;
    int roll;
    int sel;
    int q;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    repeat (count) begin
      roll = $urandom_range(99);
      sel = $urandom_range(9);
      t = 4'($urandom_range(15));
      p = (sel < 7) ? 6'($urandom_range(7)) :
          (sel < 9) ? 6'($urandom_range(31)) : 6'($urandom_range(63));
      q = pick_queued_task();
      if (roll < 35) begin
        f = prq_pkg::FUNC_INSERT;
      end else if (roll < 65) begin
        f = prq_pkg::FUNC_REMOVE;
        if (q >= 0 && $urandom_range(99) < 85) begin
          t = q[3:0];
          p = {1'b0, task_level[q]};
        end
      end else if (roll < 85) begin
        f = prq_pkg::FUNC_ROTATE;
        if (q >= 0 && $urandom_range(99) < 80) p = {1'b0, task_level[q]};
      end else begin
        f = prq_pkg::FUNC_QUERY;
      end
      send_word(f, t, p);
    end
  endtask

  task automatic test_backpressure();
    hold_requests <= hold_requests + 1;
    test_random(40, 0, 0);
    wait_results_empty();
  endtask

  initial begin
    for (int i = 0; i < TASK_SLOTS; i++) task_queued[i] = 1'b0;
    for (int i = 0; i < LEVELS; i++) lvl_count[i] = '0;
    busy_levels = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    wait_results_empty();
    test_random(450, 32, 72);
    wait_results_empty();
    test_random(450, 72, 32);
    test_backpressure();
    test_random(400, 0, 0);
    wait_results_empty();
    repeat (8) @(posedge clk);

    $display("checked %0d result words from %0d insert/remove/rotate/query words",
             words_checked, words_sent);
    $display("idle mixes 32/72, 72/32 and none, plus one long receiver hold-off");
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
